// ----- hdl/wcs_pkg.sv -----
package wcs_pkg;

   // Fixed field and table widths
   localparam int FRAC_BITS  = 8;
   localparam int ENV_DEPTH  = 256;
   localparam int ENV_AW     = 8;
   localparam int STEP_W     = 13;
   localparam int LOOP_W     = 8;
   localparam int ENV_W      = 8;
   localparam int SAMPLE_W   = 8;
   localparam int LEVEL_W    = 16;
   localparam int MODE_W     = 3;
   localparam int NOTE_W     = 6;
   localparam int ADDR_W     = 10;
   localparam int DATA_W     = 16;
   localparam int PROD_W     = 17;
   localparam int REQ_DATA_W = 32;

   localparam logic [LEVEL_W-1:0] MID_LEVEL = 16'h8000;
   localparam logic [ENV_W-1:0]   ENV_MAX   = 8'd255;

   // Input item kinds
   localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_NOTE     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WAVE_WR  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ENV_WR   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PITCH_WR = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SILENCE  = 3'd5;

   // Register file
   localparam int             CSR_AW        = 3;
   localparam int             CSR_DATA_W    = 32;
   localparam logic           CSR_IDX_DECAY = 1'b0;
   localparam logic           CSR_IDX_CLAMP = 1'b1;
   localparam logic [7:0]     DECAY_RESET   = 8'd10;
   localparam logic [14:0]    CLAMP_RESET   = 15'd32000;

   // Command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = 1;
   localparam int CMDQ_CNT_W = 2;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_NOTE    = 3'd1,
      OP_WAVE    = 3'd2,
      OP_ENV     = 3'd3,
      OP_PITCH   = 3'd4,
      OP_SILENCE = 3'd5
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                note_ok;
      logic [NOTE_W-1:0]   note;
      logic [ADDR_W-1:0]   addr;
      logic [DATA_W-1:0]   data;
   } cmd_type;

endpackage

// ----- hdl/wavetable_chord_synth_voice_mixer_core.sv -----
// Channel   Direction  Beat contents
// req_      in         tuser: mode; tdata: note, table_addr, table_data
// rsp_      out        tdata: pwm_level (one beat per tick item)
// csr_      in/out     decay_divider at 0x0, clamp_limit at 0x4
//
// In the back end a tick reads the wave and envelope tables for one voice
// per cycle, followed by multiply, accumulate and clamp stages. A note start
// reads the pitch table and then loads a voice; other items take effect as
// they leave the queue. A two-beat command queue decouples input from the
// back end, and the output register lets the next item proceed while a level
// waits. Reset clears voice state and registers; table contents stay undefined.
module wavetable_chord_synth_voice_mixer_core #(
   parameter int VOICES         = 4,
   parameter int WAVE_LENGTH    = 1024,
   parameter int SUSTAIN_LENGTH = 128,
   parameter int PITCH_ENTRIES  = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [wcs_pkg::MODE_W-1:0]       req_tuser,   // [2:0] mode
   input  logic [wcs_pkg::REQ_DATA_W-1:0]   req_tdata,   // [5:0] note, [15:6] table_addr,
                                                         // [31:16] table_data
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [wcs_pkg::LEVEL_W-1:0]      rsp_tdata,   // [15:0] pwm_level
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [wcs_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [wcs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [wcs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   logic [7:0]        decay_ff, decay_in;
   logic [14:0]       clamp_ff, clamp_in;
   logic              csr_wr;
   logic              csr_idx;
   logic              q_ready, q_push, q_pop, q_valid, tick_done;
   wcs_pkg::cmd_type  q_cmd, q_head;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      decay_in = decay_ff;
      clamp_in = clamp_ff;
      if (csr_wr && (csr_idx == wcs_pkg::CSR_IDX_DECAY)) begin
         decay_in = csr_pwdata[7:0];
      end
      if (csr_wr && (csr_idx == wcs_pkg::CSR_IDX_CLAMP)) begin
         clamp_in = csr_pwdata[14:0];
      end
      csr_prdata = (csr_idx == wcs_pkg::CSR_IDX_CLAMP) ?
                   wcs_pkg::CSR_DATA_W'(clamp_ff) : wcs_pkg::CSR_DATA_W'(decay_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= wcs_pkg::DECAY_RESET;
         clamp_ff <= wcs_pkg::CLAMP_RESET;
      end else begin
         decay_ff <= decay_in;
         clamp_ff <= clamp_in;
      end
   end

   wcs_front #(
      .WAVE_LENGTH   (WAVE_LENGTH),
      .PITCH_ENTRIES (PITCH_ENTRIES)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   wcs_cmdq u_cmdq (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head)
   );

   wcs_back #(
      .VOICES         (VOICES),
      .WAVE_LENGTH    (WAVE_LENGTH),
      .SUSTAIN_LENGTH (SUSTAIN_LENGTH),
      .PITCH_ENTRIES  (PITCH_ENTRIES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .decay_divider (decay_ff),
      .clamp_limit   (clamp_ff),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .tick_done     (tick_done)
   );

   // Register writes land on the next edge
   a_decay_wr: assert property (@(posedge clock) disable iff (reset)
      csr_wr && (csr_idx == wcs_pkg::CSR_IDX_DECAY) |=> decay_ff == $past(csr_pwdata[7:0]))
      else $error("decay_divider write lost");

   a_clamp_wr: assert property (@(posedge clock) disable iff (reset)
      csr_wr && (csr_idx == wcs_pkg::CSR_IDX_CLAMP) |=> clamp_ff == $past(csr_pwdata[14:0]))
      else $error("clamp_limit write lost");

   // A level beat only starts from a finished tick
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(tick_done))
      else $error("level beat without a finished tick");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      tick_done |=> rsp_tvalid)
      else $error("finished tick did not show a level beat");

endmodule

// ----- hdl/wcs_front.sv -----
module wcs_front #(
   parameter int WAVE_LENGTH   = 1024,
   parameter int PITCH_ENTRIES = 64
) (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [wcs_pkg::MODE_W-1:0]       req_tuser,   // [2:0] mode
   input  logic [wcs_pkg::REQ_DATA_W-1:0]   req_tdata,   // [5:0] note, [15:6] table_addr,
                                                         // [31:16] table_data
   input  logic                             q_ready,
   output logic                             q_push,
   output wcs_pkg::cmd_type                 q_cmd
);

   logic [wcs_pkg::NOTE_W-1:0] note;
   logic [wcs_pkg::ADDR_W-1:0] addr;
   logic [wcs_pkg::DATA_W-1:0] data;
   logic                       keep;
   wcs_pkg::op_type            op;

   assign note = req_tdata[5:0];
   assign addr = req_tdata[15:6];
   assign data = req_tdata[31:16];

   // Classify the beat; drop unused kinds and writes past a table's end
   always_comb begin
      keep = 1'b1;
      op   = wcs_pkg::OP_TICK;
      case (req_tuser)
         wcs_pkg::MODE_TICK: begin
            op = wcs_pkg::OP_TICK;
         end
         wcs_pkg::MODE_NOTE: begin
            op = wcs_pkg::OP_NOTE;
         end
         wcs_pkg::MODE_WAVE_WR: begin
            op   = wcs_pkg::OP_WAVE;
            keep = (32'(addr) < 32'(WAVE_LENGTH));
         end
         wcs_pkg::MODE_ENV_WR: begin
            op   = wcs_pkg::OP_ENV;
            keep = (32'(addr) < 32'(wcs_pkg::ENV_DEPTH));
         end
         wcs_pkg::MODE_PITCH_WR: begin
            op   = wcs_pkg::OP_PITCH;
            keep = (32'(addr) < 32'(PITCH_ENTRIES));
         end
         wcs_pkg::MODE_SILENCE: begin
            op = wcs_pkg::OP_SILENCE;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_tready    = q_ready;
   assign q_push        = req_tvalid && q_ready && keep;
   assign q_cmd.op      = op;
   assign q_cmd.note_ok = (32'(note) < 32'(PITCH_ENTRIES));
   assign q_cmd.note    = note;
   assign q_cmd.addr    = addr;
   assign q_cmd.data    = data;

endmodule

// ----- hdl/wcs_cmdq.sv -----
module wcs_cmdq (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  wcs_pkg::cmd_type push_cmd,
   output logic             push_ready,
   input  logic             pop,
   output logic             head_valid,
   output wcs_pkg::cmd_type head_cmd
);

   wcs_pkg::cmd_type                    slot_ff [wcs_pkg::CMDQ_DEPTH];
   logic [wcs_pkg::CMDQ_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [wcs_pkg::CMDQ_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [wcs_pkg::CMDQ_CNT_W-1:0]      count_ff, count_in;
   logic                                do_push, do_pop;

   assign push_ready = (count_ff != wcs_pkg::CMDQ_CNT_W'(wcs_pkg::CMDQ_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold the payload slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hdl/wcs_back.sv -----
module wcs_back #(
   parameter int VOICES         = 4,
   parameter int WAVE_LENGTH    = 1024,
   parameter int SUSTAIN_LENGTH = 128,
   parameter int PITCH_ENTRIES  = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  wcs_pkg::cmd_type              q_head,
   output logic                          q_pop,
   input  logic [7:0]                    decay_divider,
   input  logic [14:0]                   clamp_limit,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [wcs_pkg::LEVEL_W-1:0]   rsp_tdata,
   output logic                          tick_done
);

   localparam int VC_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int WAVE_AW  = $clog2(WAVE_LENGTH);
   localparam int PITCH_AW = $clog2(PITCH_ENTRIES);
   localparam int PHASE_W  = WAVE_AW + wcs_pkg::FRAC_BITS + 1;
   localparam int ADDR_XW  = (WAVE_AW > wcs_pkg::ADDR_W) ? WAVE_AW : wcs_pkg::ADDR_W;
   localparam int NOTE_XW  = (PITCH_AW > wcs_pkg::NOTE_W) ? PITCH_AW : wcs_pkg::NOTE_W;
   localparam int SUM_W    = 18 + VC_W;
   localparam logic [PHASE_W-1:0] PHASE_END  = PHASE_W'(WAVE_LENGTH * 256);
   localparam logic [PHASE_W-1:0] PHASE_BACK = PHASE_W'(SUSTAIN_LENGTH * 256);
   localparam logic [VC_W-1:0]    LAST_VOICE = VC_W'(VOICES - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_TICK   = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_NOTE   = 5'b10000
   } state_type;

   state_type                        state_ff, state_in;
   logic [VC_W-1:0]                  cnt_ff, cnt_in;
   logic [VC_W-1:0]                  nv_ff, nv_in;
   logic                             note_ok_ff, note_ok_in;

   // Per-voice state
   logic [wcs_pkg::STEP_W-1:0]       step_ff  [VOICES];
   logic [wcs_pkg::STEP_W-1:0]       step_in  [VOICES];
   logic [PHASE_W-1:0]               phase_ff [VOICES];
   logic [PHASE_W-1:0]               phase_in [VOICES];
   logic [wcs_pkg::LOOP_W-1:0]       loops_ff [VOICES];
   logic [wcs_pkg::LOOP_W-1:0]       loops_in [VOICES];
   logic [wcs_pkg::ENV_W-1:0]        env_ff   [VOICES];
   logic [wcs_pkg::ENV_W-1:0]        env_in   [VOICES];

   // Tables
   logic [wcs_pkg::SAMPLE_W-1:0]     wave_mem  [WAVE_LENGTH];
   logic [wcs_pkg::ENV_W-1:0]        env_mem   [wcs_pkg::ENV_DEPTH];
   logic [wcs_pkg::STEP_W-1:0]       pitch_mem [PITCH_ENTRIES];
   logic [wcs_pkg::SAMPLE_W-1:0]     wave_rd_ff;
   logic [wcs_pkg::ENV_W-1:0]        env_rd_ff;
   logic [wcs_pkg::STEP_W-1:0]       pitch_rd_ff;
   logic [WAVE_AW-1:0]               wave_ra;
   logic [PITCH_AW-1:0]              pitch_ra;
   logic [ADDR_XW-1:0]               addr_x;
   logic [NOTE_XW-1:0]               note_x;
   logic                             wave_we, env_we, pitch_we;

   // Mixer pipeline
   logic                             rd_valid_ff, rd_valid_in;
   logic                             prod_valid_ff, prod_valid_in;
   logic signed [wcs_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [SUM_W-1:0]          acc_ff, acc_in;
   logic signed [SUM_W-1:0]          scaled, lim_pos, lim_neg, clamped;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [wcs_pkg::LEVEL_W-1:0]      rsp_data_ff;
   logic                             out_load;

   // Voice update of the current tick slot
   logic [PHASE_W-1:0]               ph_sum, ph_new;
   logic [wcs_pkg::LOOP_W-1:0]       lp_inc, lp_new;
   logic [wcs_pkg::ENV_W-1:0]        env_new;
   logic                             wrap, hit;

   logic                             pop_tick, pop_note, pop_silence;

   assign q_pop       = (state_ff == ST_IDLE) && q_valid;
   assign pop_tick    = q_pop && (q_head.op == wcs_pkg::OP_TICK);
   assign pop_note    = q_pop && (q_head.op == wcs_pkg::OP_NOTE);
   assign pop_silence = q_pop && (q_head.op == wcs_pkg::OP_SILENCE);
   assign wave_we     = q_pop && (q_head.op == wcs_pkg::OP_WAVE);
   assign env_we      = q_pop && (q_head.op == wcs_pkg::OP_ENV);
   assign pitch_we    = q_pop && (q_head.op == wcs_pkg::OP_PITCH);
   assign addr_x      = ADDR_XW'(q_head.addr);
   assign note_x      = NOTE_XW'(q_head.note);
   assign pitch_ra    = note_x[PITCH_AW-1:0];

   // Advance the voice in the current slot: step, fall back, count loops and advance the envelope
   always_comb begin
      ph_sum  = phase_ff[cnt_ff] + PHASE_W'(step_ff[cnt_ff]);
      wrap    = (ph_sum >= PHASE_END);
      ph_new  = wrap ? ph_sum - PHASE_BACK : ph_sum;
      lp_inc  = loops_ff[cnt_ff] + 1'b1;
      hit     = (lp_inc == decay_divider);
      lp_new  = wrap ? (hit ? '0 : lp_inc) : loops_ff[cnt_ff];
      env_new = env_ff[cnt_ff];
      if (wrap && hit && (env_ff[cnt_ff] != wcs_pkg::ENV_MAX)) begin
         env_new = env_ff[cnt_ff] + 1'b1;
      end
      wave_ra = ph_new[wcs_pkg::FRAC_BITS +: WAVE_AW];
   end

   // Next values of every voice
   always_comb begin
      for (int v = 0; v < VOICES; v++) begin
         step_in[v]  = step_ff[v];
         phase_in[v] = phase_ff[v];
         loops_in[v] = loops_ff[v];
         env_in[v]   = env_ff[v];
         if ((state_ff == ST_TICK) && (cnt_ff == VC_W'(v))) begin
            phase_in[v] = ph_new;
            loops_in[v] = lp_new;
            env_in[v]   = env_new;
         end
         if (((state_ff == ST_NOTE) && (nv_ff == VC_W'(v))) || pop_silence) begin
            step_in[v]  = (note_ok_ff && !pop_silence) ? pitch_rd_ff : '0;
            phase_in[v] = '0;
            loops_in[v] = '0;
            env_in[v]   = '0;
         end
      end
   end

   // Sequence one item at a time
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      nv_in      = nv_ff;
      note_ok_in = note_ok_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (pop_tick) begin
               state_in = ST_TICK;
            end
            if (pop_note) begin
               state_in   = ST_NOTE;
               note_ok_in = q_head.note_ok;
            end
            if (pop_silence) begin
               nv_in = '0;
            end
         end
         ST_TICK: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_VOICE) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !prod_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         ST_NOTE: begin
            state_in = ST_IDLE;
            nv_in    = (nv_ff == LAST_VOICE) ? '0 : nv_ff + 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Multiply and accumulate behind the table reads
   always_comb begin
      rd_valid_in   = (state_ff == ST_TICK);
      prod_valid_in = rd_valid_ff;
      prod_in       = wcs_pkg::PROD_W'($signed(wave_rd_ff) * $signed({1'b0, env_rd_ff}));
      acc_in        = acc_ff;
      if (pop_tick) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + SUM_W'(prod_ff);
      end
   end

   // Scale and clamp the mix; the offset is added as the level is registered
   always_comb begin
      scaled  = acc_ff >>> 2;
      lim_pos = $signed(SUM_W'({1'b0, clamp_limit}));
      lim_neg = -lim_pos;
      if (scaled >= lim_pos) begin
         clamped = lim_pos;
      end else if (scaled <= lim_neg) begin
         clamped = lim_neg;
      end else begin
         clamped = scaled;
      end
   end

   assign out_load     = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         nv_ff         <= '0;
         note_ok_ff    <= 1'b0;
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int v = 0; v < VOICES; v++) begin
            step_ff[v]  <= '0;
            phase_ff[v] <= '0;
            loops_ff[v] <= '0;
            env_ff[v]   <= '0;
         end
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         nv_ff         <= nv_in;
         note_ok_ff    <= note_ok_in;
         rd_valid_ff   <= rd_valid_in;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         for (int v = 0; v < VOICES; v++) begin
            step_ff[v]  <= step_in[v];
            phase_ff[v] <= phase_in[v];
            loops_ff[v] <= loops_in[v];
            env_ff[v]   <= env_in[v];
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (out_load) begin
         rsp_data_ff <= clamped[wcs_pkg::LEVEL_W-1:0] + wcs_pkg::MID_LEVEL;
      end
   end

   // Table ports: one write, registered reads
   always_ff @(posedge clock) begin
      if (wave_we) begin
         wave_mem[addr_x[WAVE_AW-1:0]] <= q_head.data[wcs_pkg::SAMPLE_W-1:0];
      end
      wave_rd_ff <= wave_mem[wave_ra];
   end

   always_ff @(posedge clock) begin
      if (env_we) begin
         env_mem[q_head.addr[wcs_pkg::ENV_AW-1:0]] <= q_head.data[wcs_pkg::ENV_W-1:0];
      end
      env_rd_ff <= env_mem[env_new];
   end

   always_ff @(posedge clock) begin
      if (pitch_we) begin
         pitch_mem[q_head.addr[PITCH_AW-1:0]] <= q_head.data[wcs_pkg::STEP_W-1:0];
      end
      pitch_rd_ff <= pitch_mem[pitch_ra];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign tick_done  = out_load;

endmodule
